[rtl/mtss_pkg.sv]
// ----------------------------------------------------------------------------
// mtss_pkg
// Shared types, constants and the quarter-wave sine ROM of the multitone sine
// synthesizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mtss_pkg;

	// Sizing
	localparam int MAX_TONES       = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;

	localparam int IDX_W   = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
	localparam int CNT_W   = $clog2(MAX_TONES + 1);
	localparam int QTR_SIZE = 1 << SINE_TABLE_BITS;
	localparam int ROM_AW  = SINE_TABLE_BITS + 1;
	localparam int SINE_W  = 23;
	localparam int GAIN_W  = 24;
	localparam int STEP_W  = 32;
	localparam int PROD_W  = SINE_W + GAIN_W;
	localparam int TERM_W  = 26;
	// one sign bit plus headroom for MAX_TONES terms below 2^25
	localparam int ACC_W   = 27 + $clog2(MAX_TONES);

	// Input operations
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_TICK    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TONE_COUNT = 2'd0,
		REG_WIDTH_MODE = 2'd1,
		REG_AM_MODE    = 2'd2
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_QA,
		ST_QB,
		ST_QC,
		ST_QD
	} state_t;

	// Sequencer to tone pipeline
	typedef struct packed {
		logic             load;
		logic             restart;
		logic             issue;
		logic             acc_clr;
		logic [IDX_W-1:0] idx;
	} tone_ctl_t;

	// Sequencer to quantizer
	typedef struct packed {
		logic restart;
		logic qa;
		logic qb;
		logic qc;
		logic qd;
	} quant_ctl_t;

	// Sine ROM, Q0.23 quarter wave, QTR_SIZE+1 entries
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] SINE_MAX    = 64'd8388607;
	localparam logic [63:0] TAYLOR_DIV [7] = '{64'd210, 64'd156, 64'd110, 64'd72,
		64'd42, 64'd20, 64'd6};

	typedef logic [SINE_W-1:0] sine_rom_t [QTR_SIZE+1];

	// Horner Taylor series in Q2.30, evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		for (int k = 0; k <= QTR_SIZE; k++) begin
			x  = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int j = 0; j < 7; j++) begin
				t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[j]);
			end
			s = (x * t) >> 30;
			v = (s + 64'd64) >> 7;
			if (v > SINE_MAX) begin
				v = SINE_MAX;
			end
			rom[k] = v[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[rtl/mtss_ram.sv]
// ----------------------------------------------------------------------------
// mtss_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/mtss_tone_unit.sv]
// ----------------------------------------------------------------------------
// mtss_tone_unit
// Tone table and the shared per-tone pipe: phase read and update, sine ROM,
// gain multiply, rounding and signed accumulation. One tone per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtss_tone_unit
	import mtss_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  tone_ctl_t               ctl,
	input  logic [4:0]              load_index,
	input  logic [STEP_W-1:0]       load_step,
	input  logic [GAIN_W-1:0]       load_gain,
	output logic                    busy,
	output logic signed [31:0]      acc_sat
);

	localparam logic [ROM_AW-1:0] QTR_ADDR = ROM_AW'(QTR_SIZE);

	logic                     load_ok;
	logic [IDX_W-1:0]         load_addr;
	logic [STEP_W+GAIN_W-1:0] tone_rd;
	logic [PHASE_BITS-1:0]    ph_rd;
	logic [MAX_TONES-1:0]     ph_vld_q;

	logic                       v_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [PHASE_BITS-1:0]      ph_cur;
	logic [PHASE_BITS-1:0]      ph_next;
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] tidx;
	logic [ROM_AW-1:0]          rom_addr;

	logic              v_s2;
	logic              neg_s2;
	logic [GAIN_W-1:0] gain_s2;
	logic [SINE_W-1:0] sine_s2;

	logic              v_s3;
	logic              neg_s3;
	logic [PROD_W-1:0] prod_s3;

	logic [TERM_W-1:0]       term;
	logic signed [ACC_W-1:0] term_ext;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [63:0]      acc64;

	// Loads beyond the table are dropped
	assign load_ok   = ctl.load && (32'(load_index) < 32'(MAX_TONES));
	assign load_addr = IDX_W'(load_index);

	// Step and gain per tone
	mtss_ram #(
		.WIDTH (STEP_W + GAIN_W),
		.DEPTH (MAX_TONES)
	) u_tone_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_addr),
		.wdata ({load_step, load_gain}),
		.raddr (ctl.idx),
		.rdata (tone_rd)
	);

	// Phase accumulators, written back in stage 1
	mtss_ram #(
		.WIDTH (PHASE_BITS),
		.DEPTH (MAX_TONES)
	) u_phase_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (idx_s1),
		.wdata (ph_next),
		.raddr (ctl.idx),
		.rdata (ph_rd)
	);

	// Phase valid bits: a cleared bit reads as phase zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_vld_q <= '0;
		end else if (ctl.restart) begin
			ph_vld_q <= '0;
		end else begin
			if (load_ok) begin
				ph_vld_q[load_addr] <= 1'b0;
			end
			if (v_s1) begin
				ph_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Valid flags of the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign busy = v_s1 | v_s2 | v_s3;

	always_ff @(posedge clk) begin
		idx_s1 <= ctl.idx;
	end

	// Stage 1: phase advance and quadrant folding
	always_comb begin
		ph_cur   = ph_vld_q[idx_s1] ? ph_rd : '0;
		ph_next  = ph_cur + PHASE_BITS'(tone_rd[STEP_W+GAIN_W-1:GAIN_W]);
		quad     = ph_cur[PHASE_BITS-1:PHASE_BITS-2];
		tidx     = ph_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
		rom_addr = quad[0] ? (QTR_ADDR - {1'b0, tidx}) : {1'b0, tidx};
	end

	// Stage 2: sine ROM
	always_ff @(posedge clk) begin
		neg_s2  <= quad[1];
		gain_s2 <= tone_rd[GAIN_W-1:0];
		sine_s2 <= SINE_ROM[rom_addr];
	end

	// Stage 3: gain multiply
	always_ff @(posedge clk) begin
		neg_s3  <= neg_s2;
		prod_s3 <= PROD_W'(sine_s2) * PROD_W'(gain_s2);
	end

	// Round half away from zero on the magnitude, then sum with sign
	assign term     = TERM_W'((PROD_W'(prod_s3) + PROD_W'(1 << 21)) >> 22);
	assign term_ext = ACC_W'(term);

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= neg_s3 ? (acc_q - term_ext) : (acc_q + term_ext);
		end
	end

	// Clamp the sum to the Q8.23 word
	assign acc64 = 64'(acc_q);

	always_comb begin
		if (acc64 > 64'sh7FFF_FFFF) begin
			acc_sat = 32'sh7FFF_FFFF;
		end else if (acc64 < -64'sh8000_0000) begin
			acc_sat = 32'sh8000_0000;
		end else begin
			acc_sat = acc64[31:0];
		end
	end

endmodule

`default_nettype wire

[rtl/mtss_quant.sv]
// ----------------------------------------------------------------------------
// mtss_quant
// Per-sample post processing: AM offset and sign flip, peak tracking,
// full-scale quantization with rounding, saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtss_quant
	import mtss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  quant_ctl_t         ctl,
	input  logic signed [31:0] acc_sat,
	input  logic               width_mode,
	input  logic               am_mode,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               out_free,
	output logic signed [31:0] sample,
	output logic               clipped,
	output logic               clip_seen,
	output logic [31:0]        peak_magnitude
);

	logic               odd_q;
	logic [31:0]        peak_q;
	logic               clip_q;
	logic signed [33:0] base;
	logic signed [33:0] v_q;
	logic [32:0]        mag;
	logic [32:0]        mag_q;
	logic               neg_q;
	logic [63:0]        prod;
	logic [39:0]        q_q;
	logic [39:0]        scale;
	logic [39:0]        qsel;
	logic               clip_now;

	// Value in units of 2^-24
	assign base = 34'(acc_sat) + 34'sd8388608;

	always_ff @(posedge clk) begin
		if (ctl.qa) begin
			if (am_mode) begin
				v_q <= odd_q ? -base : base;
			end else begin
				v_q <= 34'(acc_sat) <<< 1;
			end
		end
	end

	// Magnitude
	assign mag = v_q[33] ? 33'(-v_q) : 33'(v_q);

	always_ff @(posedge clk) begin
		if (ctl.qb) begin
			mag_q <= mag;
			neg_q <= v_q[33];
		end
	end

	// mag * scale, scale being 2^31-1 or 2^15-1, plus half an LSB
	always_comb begin
		if (width_mode) begin
			prod = 64'({mag_q, 15'b0}) - 64'(mag_q) + 64'(1 << 23);
		end else begin
			prod = {mag_q, 31'b0} - 64'(mag_q) + 64'(1 << 23);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.qc) begin
			q_q <= prod[63:24];
		end
	end

	// Saturation: negative side reaches one step further
	assign scale = width_mode ? 40'd32767 : 40'd2147483647;

	always_comb begin
		clip_now = 1'b0;
		qsel     = q_q;
		if (neg_q) begin
			if (q_q > scale + 40'd1) begin
				clip_now = 1'b1;
				qsel     = scale + 40'd1;
			end
		end else begin
			if (q_q > scale) begin
				clip_now = 1'b1;
				qsel     = scale;
			end
		end
	end

	// Statistics and sample parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q  <= 1'b0;
			peak_q <= '0;
			clip_q <= 1'b0;
		end else if (ctl.restart) begin
			odd_q  <= 1'b0;
			peak_q <= '0;
			clip_q <= 1'b0;
		end else begin
			if (ctl.qa) begin
				odd_q <= ~odd_q;
			end
			if (ctl.qb && (mag[32:1] > peak_q)) begin
				peak_q <= mag[32:1];
			end
			if (ctl.qd && clip_now) begin
				clip_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.qd) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.qd) begin
			sample         <= neg_q ? (32'd0 - qsel[31:0]) : qsel[31:0];
			clipped        <= clip_now;
			clip_seen      <= clip_q | clip_now;
			peak_magnitude <= peak_q;
		end
	end

	assign out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

[rtl/mtss_ctrl.sv]
// ----------------------------------------------------------------------------
// mtss_ctrl
// Sequencer: takes items, runs loads and restarts, steps the tone pipe over
// the active tones and then walks the quantizer stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mtss_ctrl
	import mtss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  logic [5:0] tone_count,
	input  logic       busy,
	input  logic       out_free,
	output logic       in_stall,
	output tone_ctl_t  tctl,
	output quant_ctl_t qctl
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_tones;
	logic             last;
	logic             take;

	// Active tone count, clamped to the table size
	assign n_tones = (32'(tone_count) > 32'(MAX_TONES)) ? CNT_W'(MAX_TONES)
		: CNT_W'(tone_count);
	assign last    = (cnt_q + CNT_W'(1)) == n_tones;
	assign take    = (state_q == ST_IDLE) && in_valid;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (op == OP_TICK)) begin
					state_d = (n_tones == '0) ? ST_DRAIN : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = ST_QA;
				end
			end
			ST_QA:   state_d = ST_QB;
			ST_QB:   state_d = ST_QC;
			ST_QC:   state_d = ST_QD;
			ST_QD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				cnt_q <= '0;
			end else if (state_q == ST_ISSUE) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Outputs
	always_comb begin
		in_stall     = 1'b1;
		tctl         = '0;
		qctl         = '0;
		tctl.idx     = cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				tctl.load    = in_valid && (op == OP_LOAD);
				tctl.restart = in_valid && (op == OP_RESTART);
				tctl.acc_clr = in_valid && (op == OP_TICK);
				qctl.restart = in_valid && (op == OP_RESTART);
			end
			ST_ISSUE: tctl.issue = 1'b1;
			ST_DRAIN: ;
			ST_QA:    qctl.qa = 1'b1;
			ST_QB:    qctl.qb = 1'b1;
			ST_QC:    qctl.qc = 1'b1;
			ST_QD:    qctl.qd = out_free;
			default:  ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/multitone_sine_synthesizer_top.sv]
// ----------------------------------------------------------------------------
// multitone_sine_synthesizer_top
// Multitone sine synthesizer: per-tone phase accumulators, quarter-wave sine
// lookup, gain scaling and summing, with AM shaping, peak tracking and
// full-scale quantization.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     op, tone_index, phase_step,
//                                               amplitude
//   out      output     out_valid / out_stall   sample, clipped, clip_seen,
//                                               peak_magnitude
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// Load and restart items are done as they are taken. A tick item steps the
// N active tones, one tone per cycle, through the shared phase, sine ROM and
// multiplier pipe, lets the pipe drain, then walks four quantizer steps.
// Reset clears phases through per-tone valid bits; no clearing pass.
// A finished sample sits in the output register; the next item is taken
// meanwhile, and a tick waits in its last step while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multitone_sine_synthesizer_top
	import mtss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [4:0]         tone_index,
	input  logic [31:0]        phase_step,
	input  logic [23:0]        amplitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample,
	output logic               clipped,
	output logic               clip_seen,
	output logic [31:0]        peak_magnitude,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data
);

	logic [5:0]         tone_count_q;
	logic               width_mode_q;
	logic               am_mode_q;
	tone_ctl_t          tctl;
	quant_ctl_t         qctl;
	logic               busy;
	logic               out_free;
	logic signed [31:0] acc_sat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_count_q <= '0;
			width_mode_q <= 1'b0;
			am_mode_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TONE_COUNT: tone_count_q <= cfg_data;
				REG_WIDTH_MODE: width_mode_q <= cfg_data[0];
				REG_AM_MODE:    am_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mtss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.op         (op),
		.tone_count (tone_count_q),
		.busy       (busy),
		.out_free   (out_free),
		.in_stall   (in_stall),
		.tctl       (tctl),
		.qctl       (qctl)
	);

	mtss_tone_unit u_tone (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tctl),
		.load_index (tone_index),
		.load_step  (phase_step),
		.load_gain  (amplitude),
		.busy       (busy),
		.acc_sat    (acc_sat)
	);

	mtss_quant u_quant (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (qctl),
		.acc_sat        (acc_sat),
		.width_mode     (width_mode_q),
		.am_mode        (am_mode_q),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_free       (out_free),
		.sample         (sample),
		.clipped        (clipped),
		.clip_seen      (clip_seen),
		.peak_magnitude (peak_magnitude)
	);

	// A new result appears only from the final quantizer step
	a_out_from_qd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(qctl.qd))
		else $error("result appeared without a quantizer finish");

	// The final step never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.qd |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

	// Quantizing starts only after the tone pipe has drained
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.qa |-> !busy)
		else $error("quantizer started with tones in flight");

	// Tones are stepped only while no new item can enter
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tctl.issue |-> (in_stall && !tctl.load && !tctl.restart))
		else $error("tone issued while input open");

endmodule

`default_nettype wire
